// ===== src/video_beam_timing_counter_core_assert.svh =====
// assertion macros for the beam timing counter
`ifndef VIDEO_BEAM_TIMING_COUNTER_CORE_ASSERT_SVH
`define VIDEO_BEAM_TIMING_COUNTER_CORE_ASSERT_SVH

`ifndef SYNTH

`define VBTC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define VBTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VBTC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`define VBTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== src/vbtc_pkg.sv =====
`default_nettype none

package vbtc_pkg;

  localparam int unsigned CyclesW = 8;
  localparam int unsigned LineW   = 9;
  localparam int unsigned DotW    = 9;
  localparam int unsigned HorizW  = 11;
  localparam int unsigned DmaW    = 3;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned StepW   = 8;
  localparam int unsigned FrameW  = 10;
  localparam int unsigned RefW    = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 9;

  localparam logic [HorizW-1:0] LongLine   = 11'd1364;
  localparam logic [HorizW-1:0] ShortLine  = 11'd1360;
  localparam logic [HorizW-1:0] Dot323Edge = 11'd1292;
  localparam logic [HorizW-1:0] Dot327Edge = 11'd1310;
  localparam logic [HorizW-1:0] HcReset    = 11'd186;
  localparam logic [HorizW-1:0] HorizStep  = 11'd2;

  localparam logic [RefW-1:0]   RefreshStart  = 10'd538;
  localparam logic [RefW-1:0]   RefreshToggle = 10'd12;
  localparam logic [TotalW-1:0] RefreshStall  = 32'd40;
  localparam logic [StepW-1:0]  StallSteps    = 8'd20;

  localparam logic [LineW-1:0]  ShortLineNum = 9'd240;
  localparam logic [LineW-1:0]  NtscLines    = 9'd262;
  localparam logic [DmaW-1:0]   DmaMask      = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERLACE = 1'b0,
    CFG_REGION    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_ADVANCE = 1'b0,
    KIND_READ    = 1'b1
  } kind_e;

  // long dots 323 and 327 are stretched except on the short line
  function automatic logic [DotW-1:0] dot_of(input logic [HorizW-1:0] h,
                                             input logic short_line);
    logic [HorizW-1:0] adj;
    adj = h;
    if (!short_line) begin
      if (h > Dot323Edge) adj = adj - HorizStep;
      if (h > Dot327Edge) adj = adj - HorizStep;
    end
    return adj[HorizW-1:2];
  endfunction

endpackage

`default_nettype wire

// ===== src/vbtc_if.sv =====
`default_nettype none

interface vbtc_item_if;
  import vbtc_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CyclesW-1:0] cycles;

  modport source (output valid, output kind, output cycles, input ready);
  modport sink   (input valid, input kind, input cycles, output ready);
endinterface

interface vbtc_result_if;
  import vbtc_pkg::*;
  logic              valid;
  logic              ready;
  logic [LineW-1:0]  line_number;
  logic [DotW-1:0]   dot_number;
  logic [HorizW-1:0] line_cycle;
  logic              field_odd;
  logic              line_started;
  logic              frame_started;
  logic              refresh_done;
  logic [DmaW-1:0]   dma_phase;
  logic [TotalW-1:0] executed_total;

  modport source (output valid, output line_number, output dot_number, output line_cycle,
                  output field_odd, output line_started, output frame_started,
                  output refresh_done, output dma_phase, output executed_total,
                  input ready);
  modport sink   (input valid, input line_number, input dot_number, input line_cycle,
                  input field_odd, input line_started, input frame_started,
                  input refresh_done, input dma_phase, input executed_total,
                  output ready);
endinterface

interface vbtc_cfg_if;
  import vbtc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/video_beam_timing_counter_core.sv =====
// Beam timing counter: an advance item adds its cycle count to a 32-bit running total and
// walks the horizontal counter two master cycles per clock through one shared add-and-compare
// step unit, wrapping lines and fields and adding the refresh stall to the total once per line;
// a read item returns the total and clears it. An advance item stays in work for half its
// cycle count in steps, plus StallSteps more when a refresh stall falls inside it, then ends
// in the finish state; a read item goes straight to the finish state. The input is not
// ready while an item is in work; one result register sits on the output, so a finished
// result may wait while the next item is taken. Configuration writes are taken in any cycle,
// and the region setting takes effect at the next frame wrap.
`default_nettype none

`include "video_beam_timing_counter_core_assert.svh"

module video_beam_timing_counter_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  vbtc_item_if.sink      item_i,
  vbtc_result_if.source  result_o,
  vbtc_cfg_if.sink       cfg_i
);
  import vbtc_pkg::*;

  state_e            state_q, state_d;
  logic              interlace_q;
  logic [LineW-1:0]  region_q;
  logic [LineW-1:0]  vert_q, vert_d;
  logic [HorizW-1:0] horiz_q, horiz_d;
  logic              field_q, field_d;
  logic [FrameW-1:0] ltf_q, ltf_d;
  logic              short_q, short_d;
  logic              refreshed_q, refreshed_d;
  logic [RefW-1:0]   refpos_q, refpos_d;
  logic [DmaW-1:0]   dma_base_q, dma_base_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [TotalW-1:0] total_out_q, total_out_d;
  logic [StepW-1:0]  steps_q, steps_d;
  logic              line_f_q, line_f_d;
  logic              frame_f_q, frame_f_d;
  logic              refr_f_q, refr_f_d;
  logic              out_valid_q, out_valid_d;
  logic              load_out;

  logic [LineW-1:0]  res_line_q;
  logic [DotW-1:0]   res_dot_q;
  logic [HorizW-1:0] res_cycle_q;
  logic              res_field_q;
  logic              res_line_f_q;
  logic              res_frame_f_q;
  logic              res_refr_f_q;
  logic [DmaW-1:0]   res_dma_q;
  logic [TotalW-1:0] res_total_q;

  logic [HorizW-1:0] hc_inc;
  logic [HorizW-1:0] line_len;
  logic [FrameW-1:0] vert_inc;
  logic              wrap_frame;
  logic [LineW-1:0]  vert_new;
  logic              field_new;
  logic              on_short;
  logic [StepW-1:0]  steps_next;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interlace_q <= 1'b0;
      region_q    <= NtscLines;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_INTERLACE: interlace_q <= cfg_i.data[0];
        CFG_REGION:    region_q    <= cfg_i.data[LineW-1:0];
        default: ;
      endcase
    end
  end

  // shared step unit
  assign hc_inc     = horiz_q + HorizStep;
  assign line_len   = short_q ? ShortLine : LongLine;
  assign vert_inc   = {1'b0, vert_q} + FrameW'(1);
  assign wrap_frame = (vert_inc >= ltf_q);
  assign vert_new   = wrap_frame ? '0 : vert_inc[LineW-1:0];
  assign field_new  = field_q ^ wrap_frame;
  assign on_short   = (vert_q == ShortLineNum) && !interlace_q && field_q;

  always_comb begin
    state_d     = state_q;
    vert_d      = vert_q;
    horiz_d     = horiz_q;
    field_d     = field_q;
    ltf_d       = ltf_q;
    short_d     = short_q;
    refreshed_d = refreshed_q;
    refpos_d    = refpos_q;
    dma_base_d  = dma_base_q;
    total_d     = total_q;
    total_out_d = total_out_q;
    steps_d     = steps_q;
    line_f_d    = line_f_q;
    frame_f_d   = frame_f_q;
    refr_f_d    = refr_f_q;
    steps_next  = steps_q - StepW'(1);
    load_out    = 1'b0;
    item_i.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          line_f_d  = 1'b0;
          frame_f_d = 1'b0;
          refr_f_d  = 1'b0;
          if (item_i.kind == KIND_READ) begin
            total_out_d = total_q;
            total_d     = '0;
            state_d     = ST_FINISH;
          end else begin
            total_out_d = '0;
            total_d     = total_q + TotalW'(item_i.cycles);
            steps_d     = StepW'(item_i.cycles[CyclesW-1:1]);
            state_d     = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (steps_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          if (hc_inc >= line_len) begin
            line_f_d    = 1'b1;
            frame_f_d   = frame_f_q | wrap_frame;
            vert_d      = vert_new;
            field_d     = field_new;
            if (wrap_frame) begin
              if (interlace_q && !field_new) ltf_d = {1'b0, region_q} + FrameW'(1);
              else ltf_d = {1'b0, region_q};
            end
            horiz_d     = '0;
            dma_base_d  = line_len[DmaW-1:0] & DmaMask;
            short_d     = (vert_new == ShortLineNum) && !interlace_q && field_new;
            refreshed_d = 1'b0;
          end else begin
            horiz_d = hc_inc;
            if (!refreshed_q && (hc_inc >= {1'b0, refpos_q})) begin
              refreshed_d = 1'b1;
              refr_f_d    = 1'b1;
              total_d     = total_q + RefreshStall;
              steps_next  = steps_next + StallSteps;
              if (!on_short) refpos_d = refpos_q ^ RefreshToggle;
            end
          end
          steps_d = steps_next;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = load_out | (out_valid_q & ~result_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vert_q      <= '0;
      horiz_q     <= HcReset;
      field_q     <= 1'b0;
      ltf_q       <= {1'b0, NtscLines};
      short_q     <= 1'b0;
      refreshed_q <= 1'b0;
      refpos_q    <= RefreshStart;
      dma_base_q  <= '0;
      total_q     <= '0;
      total_out_q <= '0;
      steps_q     <= '0;
      line_f_q    <= 1'b0;
      frame_f_q   <= 1'b0;
      refr_f_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vert_q      <= vert_d;
      horiz_q     <= horiz_d;
      field_q     <= field_d;
      ltf_q       <= ltf_d;
      short_q     <= short_d;
      refreshed_q <= refreshed_d;
      refpos_q    <= refpos_d;
      dma_base_q  <= dma_base_d;
      total_q     <= total_d;
      total_out_q <= total_out_d;
      steps_q     <= steps_d;
      line_f_q    <= line_f_d;
      frame_f_q   <= frame_f_d;
      refr_f_q    <= refr_f_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_line_q    <= vert_q;
      res_dot_q     <= dot_of(horiz_q, on_short);
      res_cycle_q   <= horiz_q;
      res_field_q   <= field_q;
      res_line_f_q  <= line_f_q;
      res_frame_f_q <= frame_f_q;
      res_refr_f_q  <= refr_f_q;
      res_dma_q     <= (dma_base_q + horiz_q[DmaW-1:0]) & DmaMask;
      res_total_q   <= total_out_q;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.line_number    = res_line_q;
  assign result_o.dot_number     = res_dot_q;
  assign result_o.line_cycle     = res_cycle_q;
  assign result_o.field_odd      = res_field_q;
  assign result_o.line_started   = res_line_f_q;
  assign result_o.frame_started  = res_frame_f_q;
  assign result_o.refresh_done   = res_refr_f_q;
  assign result_o.dma_phase      = res_dma_q;
  assign result_o.executed_total = res_total_q;

  `VBTC_ASSERT_IMPLIES(a_horiz_in_line, clk_i, rst_ni, 1'b1, (horiz_q < line_len), "horizontal count beyond line length")
  `VBTC_ASSERT_IMPLIES(a_frame_has_line, clk_i, rst_ni, frame_f_q, line_f_q, "frame start without line start")
  `VBTC_ASSERT_NEXT(a_read_clears, clk_i, rst_ni, (item_i.valid && item_i.ready && item_i.kind == KIND_READ), (total_q == '0), "total not cleared after read")
  `VBTC_ASSERT_IMPLIES(a_refresh_rearm, clk_i, rst_ni, $fell(refreshed_q), (horiz_q == '0), "refresh rearmed away from line start")

endmodule

`default_nettype wire
